// File: hdl/ada_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and fixed-point helpers of the AdaMod update unit.
package ada_pkg;

   localparam int FRAC_BITS  = 24;
   localparam int WORD_WIDTH = 32;
   localparam int CFG_WIDTH  = 24;
   localparam int CORR_WIDTH = 32;

   localparam logic [24:0]        ONE_Q       = 25'd1 << FRAC_BITS;
   localparam logic [63:0]        HALF_Q      = 64'd1 << (FRAC_BITS - 1);
   localparam logic signed [63:0] HALF_Q_S    = 64'sd1 <<< (FRAC_BITS - 1);
   localparam logic signed [63:0] SAT_MAX     = (64'sd1 <<< (WORD_WIDTH - 1)) - 64'sd1;
   localparam logic signed [63:0] SAT_MIN     = -SAT_MAX - 64'sd1;
   localparam logic [63:0]        SAT_MAX_U   = 64'(SAT_MAX);

   // A weight step is never larger than the whole word range.
   localparam logic [32:0]        STEP_CAP    = 33'h1_0000_0000;

   localparam logic [23:0] LEARN_RATE_RST   = 24'd16777;
   localparam logic [23:0] FIRST_DECAY_RST  = 24'd15099494;
   localparam logic [23:0] SECOND_DECAY_RST = 24'd16760438;
   localparam logic [23:0] LONG_DECAY_RST   = 24'd16760438;
   localparam logic [23:0] EPSILON_RST      = 24'd1;
   localparam logic [23:0] DECAY_WEIGHT_RST = 24'd0;
   localparam logic [31:0] INV_CORR_RST     = 32'd65536;

   localparam int SQRT_STEPS     = 32;
   localparam int SQRT_PER_STAGE = 4;
   localparam int SQRT_STAGES    = SQRT_STEPS / SQRT_PER_STAGE;
   localparam int DIV_STEPS      = 33;
   localparam int DIV_PER_STAGE  = 4;
   localparam int DIV_STAGES     = (DIV_STEPS + DIV_PER_STAGE - 1) / DIV_PER_STAGE;
   localparam int LATENCY        = 10 + SQRT_STAGES + DIV_STAGES;

   typedef enum logic [2:0] {
      CSR_LEARN_RATE   = 3'd0,
      CSR_FIRST_DECAY  = 3'd1,
      CSR_SECOND_DECAY = 3'd2,
      CSR_LONG_DECAY   = 3'd3,
      CSR_EPSILON      = 3'd4,
      CSR_DECAY_WEIGHT = 3'd5,
      CSR_INV_CORR_ONE = 3'd6,
      CSR_INV_CORR_TWO = 3'd7
   } ada_csr_type;

   // Values that ride along with an element through the root and divider pipes.
   typedef struct packed {
      logic [31:0] weight;
      logic [31:0] mean;
      logic [30:0] square;
      logic [30:0] longterm;
      logic        neg;
      logic [71:0] num;
   } ada_side_type;

   function automatic logic [31:0] sat_signed(input logic signed [63:0] x);
      logic [31:0] r;
      priority if (x > SAT_MAX) begin
         r = 32'h7FFF_FFFF;
      end else if (x < SAT_MIN) begin
         r = 32'h8000_0000;
      end else begin
         r = x[31:0];
      end
      return r;
   endfunction

   function automatic logic [31:0] round_sat_signed(input logic signed [63:0] x);
      logic signed [63:0] t;
      t = (x + HALF_Q_S) >>> FRAC_BITS;
      return sat_signed(t);
   endfunction

   function automatic logic [30:0] sat_unsigned(input logic [63:0] x);
      logic [30:0] r;
      if (x > SAT_MAX_U) begin
         r = 31'h7FFF_FFFF;
      end else begin
         r = x[30:0];
      end
      return r;
   endfunction

   function automatic logic [30:0] round_sat_unsigned(input logic [63:0] x);
      return sat_unsigned((x + HALF_Q) >> FRAC_BITS);
   endfunction

endpackage

// File: hdl/ada_sqrt_pipe.sv
`timescale 1ns / 1ps
// Pipelined digit-by-digit integer square root, four result bits per stage.
module ada_sqrt_pipe (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic [63:0]          in_rad,
   input  ada_pkg::ada_side_type in_side,
   output logic                 out_valid,
   output logic [31:0]          out_root,
   output ada_pkg::ada_side_type out_side
);

   logic                  vld_ff   [ada_pkg::SQRT_STAGES];
   logic                  vld_in   [ada_pkg::SQRT_STAGES];
   logic [63:0]           rad_ff   [ada_pkg::SQRT_STAGES];
   logic [63:0]           rad_in   [ada_pkg::SQRT_STAGES];
   logic [33:0]           rem_ff   [ada_pkg::SQRT_STAGES];
   logic [33:0]           rem_in   [ada_pkg::SQRT_STAGES];
   logic [31:0]           root_ff  [ada_pkg::SQRT_STAGES];
   logic [31:0]           root_in  [ada_pkg::SQRT_STAGES];
   ada_pkg::ada_side_type side_ff  [ada_pkg::SQRT_STAGES];
   ada_pkg::ada_side_type side_in  [ada_pkg::SQRT_STAGES];

   always_comb begin : steps
      logic [63:0] rad;
      logic [33:0] rem;
      logic [31:0] root;
      logic [35:0] rem2;
      logic [35:0] trial;
      for (int k = 0; k < ada_pkg::SQRT_STAGES; k++) begin
         if (k == 0) begin
            vld_in[k]  = in_valid;
            side_in[k] = in_side;
            rad        = in_rad;
            rem        = '0;
            root       = '0;
         end else begin
            vld_in[k]  = vld_ff[k-1];
            side_in[k] = side_ff[k-1];
            rad        = rad_ff[k-1];
            rem        = rem_ff[k-1];
            root       = root_ff[k-1];
         end
         for (int j = 0; j < ada_pkg::SQRT_PER_STAGE; j++) begin
            rem2  = {rem, rad[63:62]};
            trial = {2'b00, root, 2'b01};
            rad   = {rad[61:0], 2'b00};
            if (rem2 >= trial) begin
               rem2 = rem2 - trial;
               root = {root[30:0], 1'b1};
            end else begin
               root = {root[30:0], 1'b0};
            end
            rem = rem2[33:0];
         end
         rad_in[k]  = rad;
         rem_in[k]  = rem;
         root_in[k] = root;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < ada_pkg::SQRT_STAGES; k++) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= vld_in[k];
         end
         rad_ff[k]  <= rad_in[k];
         rem_ff[k]  <= rem_in[k];
         root_ff[k] <= root_in[k];
         side_ff[k] <= side_in[k];
      end
   end

   assign out_valid = vld_ff[ada_pkg::SQRT_STAGES-1];
   assign out_root  = root_ff[ada_pkg::SQRT_STAGES-1];
   assign out_side  = side_ff[ada_pkg::SQRT_STAGES-1];

endmodule

// File: hdl/ada_div_pipe.sv
`timescale 1ns / 1ps
// Pipelined restoring divider giving a 33-bit quotient and an overflow flag.
module ada_div_pipe (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic [31:0]          in_den,
   input  ada_pkg::ada_side_type in_side,
   output logic                 out_valid,
   output logic [32:0]          out_quot,
   output logic                 out_big,
   output ada_pkg::ada_side_type out_side
);

   logic                  vld_ff  [ada_pkg::DIV_STAGES];
   logic                  vld_in  [ada_pkg::DIV_STAGES];
   logic [31:0]           den_ff  [ada_pkg::DIV_STAGES];
   logic [31:0]           den_in  [ada_pkg::DIV_STAGES];
   logic [31:0]           rem_ff  [ada_pkg::DIV_STAGES];
   logic [31:0]           rem_in  [ada_pkg::DIV_STAGES];
   logic [32:0]           lo_ff   [ada_pkg::DIV_STAGES];
   logic [32:0]           lo_in   [ada_pkg::DIV_STAGES];
   logic [32:0]           quot_ff [ada_pkg::DIV_STAGES];
   logic [32:0]           quot_in [ada_pkg::DIV_STAGES];
   logic                  big_ff  [ada_pkg::DIV_STAGES];
   logic                  big_in  [ada_pkg::DIV_STAGES];
   ada_pkg::ada_side_type side_ff [ada_pkg::DIV_STAGES];
   ada_pkg::ada_side_type side_in [ada_pkg::DIV_STAGES];

   always_comb begin : steps
      logic [38:0] top;
      logic [31:0] den;
      logic [31:0] rem;
      logic [32:0] lo;
      logic [32:0] quot;
      logic [32:0] rem2;
      for (int k = 0; k < ada_pkg::DIV_STAGES; k++) begin
         if (k == 0) begin
            // The quotient overflows 33 bits when the upper part already reaches the divisor.
            top        = in_side.num[71:33];
            den        = in_den;
            vld_in[k]  = in_valid;
            side_in[k] = in_side;
            big_in[k]  = (top >= {7'd0, in_den});
            rem        = top[31:0];
            lo         = in_side.num[32:0];
            quot       = '0;
         end else begin
            top        = '0;
            den        = den_ff[k-1];
            vld_in[k]  = vld_ff[k-1];
            side_in[k] = side_ff[k-1];
            big_in[k]  = big_ff[k-1];
            rem        = rem_ff[k-1];
            lo         = lo_ff[k-1];
            quot       = quot_ff[k-1];
         end
         for (int j = 0; j < ada_pkg::DIV_PER_STAGE; j++) begin
            if (k * ada_pkg::DIV_PER_STAGE + j < ada_pkg::DIV_STEPS) begin
               rem2 = {rem, lo[32]};
               lo   = {lo[31:0], 1'b0};
               if (rem2 >= {1'b0, den}) begin
                  rem2 = rem2 - {1'b0, den};
                  quot = {quot[31:0], 1'b1};
               end else begin
                  quot = {quot[31:0], 1'b0};
               end
               rem = rem2[31:0];
            end
         end
         den_in[k]  = den;
         rem_in[k]  = rem;
         lo_in[k]   = lo;
         quot_in[k] = quot;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < ada_pkg::DIV_STAGES; k++) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= vld_in[k];
         end
         den_ff[k]  <= den_in[k];
         rem_ff[k]  <= rem_in[k];
         lo_ff[k]   <= lo_in[k];
         quot_ff[k] <= quot_in[k];
         big_ff[k]  <= big_in[k];
         side_ff[k] <= side_in[k];
      end
   end

   assign out_valid = vld_ff[ada_pkg::DIV_STAGES-1];
   assign out_quot  = quot_ff[ada_pkg::DIV_STAGES-1];
   assign out_big   = big_ff[ada_pkg::DIV_STAGES-1];
   assign out_side  = side_ff[ada_pkg::DIV_STAGES-1];

endmodule

// File: hdl/adamod_optimizer_update_unit.sv
`timescale 1ns / 1ps
// Top level of the AdaMod per-element optimizer update pipeline.
//
//  channel   | handshake              | payload
//  ----------+------------------------+--------------------------------------------
//  request   | start, busy            | req_weight_in, req_gradient, req_mean_in,
//            |                        | req_square_in, req_longterm_in
//  response  | rsp_valid (strobe)     | rsp_weight_out, rsp_mean_out,
//            |                        | rsp_square_out, rsp_longterm_out
//  csr write | csr_valid, csr_ready   | csr_index, csr_data
//
// One request enters per clock while busy is low; its response strobes out at the end of
// the pipeline, which holds the pipelined square root (eight stages of four root
// bits) and the pipelined divider (nine stages of up to four quotient bits each).
// Reset is synchronous and touches only the valid bits, the busy flag (set) and the CSRs (reset values);
// busy is high during reset and the first cycle after it, low afterwards.
// The response side cannot stall, so the pipeline always advances.
module adamod_optimizer_update_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_weight_in,
   input  logic signed [31:0] req_gradient,
   input  logic signed [31:0] req_mean_in,
   input  logic [30:0]        req_square_in,
   input  logic [30:0]        req_longterm_in,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_weight_out,
   output logic signed [31:0] rsp_mean_out,
   output logic [30:0]        rsp_square_out,
   output logic [30:0]        rsp_longterm_out,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_data
);

   // Control and status registers.
   logic [23:0] lr_ff, b1_ff, b2_ff, b3_ff, eps_ff, wd_ff;
   logic [31:0] ic1_ff, ic2_ff;
   logic        busy_ff;

   // The one-minus-beta factors are at most one, so they need 25 bits.
   logic [24:0] om1, om2, om3;
   logic        accept;

   assign csr_ready = 1'b1;
   assign busy      = busy_ff;
   assign accept    = start && !busy_ff;
   assign om1       = ada_pkg::ONE_Q - {1'b0, b1_ff};
   assign om2       = ada_pkg::ONE_Q - {1'b0, b2_ff};
   assign om3       = ada_pkg::ONE_Q - {1'b0, b3_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         lr_ff   <= ada_pkg::LEARN_RATE_RST;
         b1_ff   <= ada_pkg::FIRST_DECAY_RST;
         b2_ff   <= ada_pkg::SECOND_DECAY_RST;
         b3_ff   <= ada_pkg::LONG_DECAY_RST;
         eps_ff  <= ada_pkg::EPSILON_RST;
         wd_ff   <= ada_pkg::DECAY_WEIGHT_RST;
         ic1_ff  <= ada_pkg::INV_CORR_RST;
         ic2_ff  <= ada_pkg::INV_CORR_RST;
      end else begin
         busy_ff <= 1'b0;
         if (csr_valid && csr_ready) begin
            unique case (ada_pkg::ada_csr_type'(csr_index))
               ada_pkg::CSR_LEARN_RATE:   lr_ff  <= csr_data[23:0];
               ada_pkg::CSR_FIRST_DECAY:  b1_ff  <= csr_data[23:0];
               ada_pkg::CSR_SECOND_DECAY: b2_ff  <= csr_data[23:0];
               ada_pkg::CSR_LONG_DECAY:   b3_ff  <= csr_data[23:0];
               ada_pkg::CSR_EPSILON:      eps_ff <= csr_data[23:0];
               ada_pkg::CSR_DECAY_WEIGHT: wd_ff  <= csr_data[23:0];
               ada_pkg::CSR_INV_CORR_ONE: ic1_ff <= csr_data;
               ada_pkg::CSR_INV_CORR_TWO: ic2_ff <= csr_data;
            endcase
         end
      end
   end

   // Valid bits of the stages around the two pipes.
   logic va_ff, vb_ff, vc_ff, vd_ff, ve_ff, vf_ff, vg_ff, vh_ff, vi_ff, rsp_valid_ff;
   logic sqrt_valid, div_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff        <= 1'b0;
         vb_ff        <= 1'b0;
         vc_ff        <= 1'b0;
         vd_ff        <= 1'b0;
         ve_ff        <= 1'b0;
         vf_ff        <= 1'b0;
         vg_ff        <= 1'b0;
         vh_ff        <= 1'b0;
         vi_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         va_ff        <= accept;
         vb_ff        <= va_ff;
         vc_ff        <= vb_ff;
         vd_ff        <= vc_ff;
         ve_ff        <= vd_ff;
         vf_ff        <= ve_ff;
         vg_ff        <= vf_ff;
         vh_ff        <= sqrt_valid;
         vi_ff        <= vh_ff;
         rsp_valid_ff <= div_valid;
      end
   end

   // Stage A: the request is registered as it is taken.
   logic signed [31:0] a_w_ff, a_g_ff, a_m_ff;
   logic [30:0]        a_v_ff, a_s_ff;

   always_ff @(posedge clock) begin
      a_w_ff <= req_weight_in;
      a_g_ff <= req_gradient;
      a_m_ff <= req_mean_in;
      a_v_ff <= req_square_in;
      a_s_ff <= req_longterm_in;
   end

   // Stage B: the first moment products, the gradient square and lr times decay.
   logic signed [57:0] b_mb_ff, b_mb_in, b_gb_ff, b_gb_in;
   logic [63:0]        b_gg_ff, b_gg_in;
   logic [47:0]        b_lwp_ff, b_lwp_in;
   logic signed [31:0] b_w_ff;
   logic [30:0]        b_v_ff, b_s_ff;

   assign b_mb_in  = $signed(a_m_ff) * $signed({1'b0, b1_ff});
   assign b_gb_in  = $signed(a_g_ff) * $signed({1'b0, om1});
   assign b_gg_in  = 64'($signed(a_g_ff) * $signed(a_g_ff));
   assign b_lwp_in = lr_ff * wd_ff;

   always_ff @(posedge clock) begin
      b_mb_ff  <= b_mb_in;
      b_gb_ff  <= b_gb_in;
      b_gg_ff  <= b_gg_in;
      b_lwp_ff <= b_lwp_in;
      b_w_ff   <= a_w_ff;
      b_v_ff   <= a_v_ff;
      b_s_ff   <= a_s_ff;
   end

   // Stage C: the new first moment, the rounded gradient square and the decay factor.
   logic [31:0]        c_m1_ff, c_m1_in;
   logic [38:0]        c_g2_ff, c_g2_in;
   logic [24:0]        c_fac_ff, c_fac_in;
   logic signed [31:0] c_w_ff;
   logic [30:0]        c_v_ff, c_s_ff;

   assign c_m1_in  = ada_pkg::round_sat_signed(64'(b_mb_ff) + 64'(b_gb_ff));
   assign c_g2_in  = 39'((b_gg_ff + ada_pkg::HALF_Q) >> ada_pkg::FRAC_BITS);
   assign c_fac_in = ada_pkg::ONE_Q -
                     25'((64'(b_lwp_ff) + ada_pkg::HALF_Q) >> ada_pkg::FRAC_BITS);

   always_ff @(posedge clock) begin
      c_m1_ff  <= c_m1_in;
      c_g2_ff  <= c_g2_in;
      c_fac_ff <= c_fac_in;
      c_w_ff   <= b_w_ff;
      c_v_ff   <= b_v_ff;
      c_s_ff   <= b_s_ff;
   end

   // Stage D: second moment products, the bias-corrected mean and the decayed weight.
   logic [54:0]        d_vb_ff, d_vb_in;
   logic [63:0]        d_g2b_ff, d_g2b_in;
   logic signed [64:0] d_mh_ff, d_mh_in;
   logic signed [56:0] d_wm_ff, d_wm_in;
   logic signed [31:0] d_w_ff;
   logic [31:0]        d_m1_ff;
   logic [30:0]        d_s_ff;

   assign d_vb_in  = c_v_ff * b2_ff;
   assign d_g2b_in = c_g2_ff * om2;
   assign d_mh_in  = $signed(c_m1_ff) * $signed({1'b0, ic1_ff});
   assign d_wm_in  = c_w_ff * $signed({1'b0, c_fac_ff});

   always_ff @(posedge clock) begin
      d_vb_ff  <= d_vb_in;
      d_g2b_ff <= d_g2b_in;
      d_mh_ff  <= d_mh_in;
      d_wm_ff  <= d_wm_in;
      d_w_ff   <= c_w_ff;
      d_m1_ff  <= c_m1_ff;
      d_s_ff   <= c_s_ff;
   end

   // Stage E: the new second moment, the magnitude and sign of the corrected mean,
   // and the weight after decoupled decay (skipped when the decay weight is zero).
   logic [30:0]        e_v1_ff, e_v1_in;
   logic [47:0]        e_mag_ff, e_mag_in;
   logic               e_neg_ff, e_neg_in;
   logic [31:0]        e_w1_ff, e_w1_in;
   logic [31:0]        e_m1_ff;
   logic [30:0]        e_s_ff;
   logic signed [64:0] mh_rnd;
   logic signed [48:0] mhat;

   assign e_v1_in  = ada_pkg::round_sat_unsigned(64'(d_vb_ff) + d_g2b_ff);
   assign mh_rnd   = d_mh_ff + 65'sd32768;
   assign mhat     = 49'(mh_rnd >>> 16);
   assign e_neg_in = mhat[48];
   assign e_mag_in = mhat[48] ? 48'(-mhat) : 48'(mhat);
   assign e_w1_in  = (wd_ff != '0) ? ada_pkg::round_sat_signed(64'(d_wm_ff)) : d_w_ff;

   always_ff @(posedge clock) begin
      e_v1_ff  <= e_v1_in;
      e_mag_ff <= e_mag_in;
      e_neg_ff <= e_neg_in;
      e_w1_ff  <= e_w1_in;
      e_m1_ff  <= d_m1_ff;
      e_s_ff   <= d_s_ff;
   end

   // Stage F: the corrected second moment and the two halves of lr times the mean.
   logic [62:0] f_vh_ff, f_vh_in;
   logic [47:0] f_pa_ff, f_pa_in, f_pb_ff, f_pb_in;
   logic [31:0] f_w1_ff, f_m1_ff;
   logic [30:0] f_v1_ff, f_s_ff;
   logic        f_neg_ff;

   assign f_vh_in = e_v1_ff * ic2_ff;
   assign f_pa_in = lr_ff * e_mag_ff[47:24];
   assign f_pb_in = lr_ff * e_mag_ff[23:0];

   always_ff @(posedge clock) begin
      f_vh_ff  <= f_vh_in;
      f_pa_ff  <= f_pa_in;
      f_pb_ff  <= f_pb_in;
      f_w1_ff  <= e_w1_ff;
      f_m1_ff  <= e_m1_ff;
      f_v1_ff  <= e_v1_ff;
      f_s_ff   <= e_s_ff;
      f_neg_ff <= e_neg_ff;
   end

   // Stage G: the radicand is the corrected second moment, clamped so that its
   // shift into fraction position stays inside 64 bits; the numerator is assembled.
   logic [47:0]           vh_rnd;
   logic [39:0]           vhat;
   logic [63:0]           g_rad_ff, g_rad_in;
   ada_pkg::ada_side_type g_side_ff, g_side_in;

   assign vh_rnd   = 48'((64'(f_vh_ff) + 64'd32768) >> 16);
   assign vhat     = (vh_rnd > 48'hFF_FFFF_FFFF) ? 40'hFF_FFFF_FFFF : vh_rnd[39:0];
   assign g_rad_in = {vhat, 24'd0};

   always_comb begin
      g_side_in.weight   = f_w1_ff;
      g_side_in.mean     = f_m1_ff;
      g_side_in.square   = f_v1_ff;
      g_side_in.longterm = f_s_ff;
      g_side_in.neg      = f_neg_ff;
      g_side_in.num      = {f_pa_ff, 24'd0} + 72'(f_pb_ff);
   end

   always_ff @(posedge clock) begin
      g_rad_ff  <= g_rad_in;
      g_side_ff <= g_side_in;
   end

   // Square root of the corrected second moment.
   logic [31:0]           sqrt_root;
   ada_pkg::ada_side_type sqrt_side;

   ada_sqrt_pipe u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vg_ff),
      .in_rad    (g_rad_ff),
      .in_side   (g_side_ff),
      .out_valid (sqrt_valid),
      .out_root  (sqrt_root),
      .out_side  (sqrt_side)
   );

   // Stage H: the products of the long-term average.
   logic [54:0]           h_sb_ff, h_sb_in;
   logic [56:0]           h_rb_ff, h_rb_in;
   ada_pkg::ada_side_type h_side_ff;

   assign h_sb_in = sqrt_side.longterm * b3_ff;
   assign h_rb_in = sqrt_root * om3;

   always_ff @(posedge clock) begin
      h_sb_ff   <= h_sb_in;
      h_rb_ff   <= h_rb_in;
      h_side_ff <= sqrt_side;
   end

   // Stage I: the new long-term value and the divisor; a zero divisor becomes one LSB.
   logic [30:0]           s1;
   logic [31:0]           den_sum;
   logic [31:0]           i_den_ff, i_den_in;
   ada_pkg::ada_side_type i_side_ff, i_side_in;

   assign s1       = ada_pkg::round_sat_unsigned(64'(h_sb_ff) + 64'(h_rb_ff));
   assign den_sum  = {1'b0, s1} + {8'd0, eps_ff};
   assign i_den_in = (den_sum == '0) ? 32'd1 : den_sum;

   always_comb begin
      i_side_in          = h_side_ff;
      i_side_in.longterm = s1;
   end

   always_ff @(posedge clock) begin
      i_den_ff  <= i_den_in;
      i_side_ff <= i_side_in;
   end

   // Quotient of lr times the corrected mean over the divisor.
   logic [32:0]           div_quot;
   logic                  div_big;
   ada_pkg::ada_side_type div_side;

   ada_div_pipe u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vi_ff),
      .in_den    (i_den_ff),
      .in_side   (i_side_ff),
      .out_valid (div_valid),
      .out_quot  (div_quot),
      .out_big   (div_big),
      .out_side  (div_side)
   );

   // Output stage: the step is clipped at 2^32 LSB and applied against the mean's sign.
   logic [32:0]        step;
   logic signed [63:0] w_ext, step_ext;
   logic [31:0]        rsp_w_ff, rsp_w_in, rsp_m_ff;
   logic [30:0]        rsp_v_ff, rsp_s_ff;

   assign step     = (div_big || div_quot > ada_pkg::STEP_CAP) ? ada_pkg::STEP_CAP
                                                               : div_quot;
   assign w_ext    = 64'($signed(div_side.weight));
   assign step_ext = $signed({31'd0, step});
   assign rsp_w_in = div_side.neg ? ada_pkg::sat_signed(w_ext + step_ext)
                                  : ada_pkg::sat_signed(w_ext - step_ext);

   always_ff @(posedge clock) begin
      rsp_w_ff <= rsp_w_in;
      rsp_m_ff <= div_side.mean;
      rsp_v_ff <= div_side.square;
      rsp_s_ff <= div_side.longterm;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_weight_out   = $signed(rsp_w_ff);
   assign rsp_mean_out     = $signed(rsp_m_ff);
   assign rsp_square_out   = rsp_v_ff;
   assign rsp_longterm_out = rsp_s_ff;

endmodule

// File: hdl/ada_checker.sv
`timescale 1ns / 1ps
// Port-level checker of the AdaMod update unit and its bind to the top level.
module ada_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid
);

   // Reset empties the pipeline, so no response may follow it directly.
   a_no_rsp_after_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response strobe right after reset");

   // Requests are refused while the unit comes out of reset.
   a_busy_after_reset: assert property (@(posedge clock) reset |=> busy)
      else $error("busy low right after reset");

   // Every taken request yields its response.
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##(ada_pkg::LATENCY) rsp_valid)
      else $error("response missing after a request");

   // No response appears without a taken request before it.
   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, ada_pkg::LATENCY))
      else $error("response without a request");

endmodule

bind adamod_optimizer_update_unit ada_checker u_ada_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid)
);
